### hw/rtl/vsar_pkg.sv
// Shared types and constants of the video scroll and address registers.
`default_nettype none
package vsar_pkg;

    localparam int MODE_W = 4;
    localparam int DATA_W = 8;
    localparam int ADDR_W = 15;
    localparam int FINE_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_CTRL_WR       = 4'd0,
        MODE_MASK_WR       = 4'd1,
        MODE_SCROLL_WR     = 4'd2,
        MODE_ADDR_WR       = 4'd3,
        MODE_DATA_WR       = 4'd4,
        MODE_STATUS_RD     = 4'd5,
        MODE_DATA_RD       = 4'd6,
        MODE_TILE_TICK     = 4'd7,
        MODE_LINE_END      = 4'd8,
        MODE_PRERENDER_END = 4'd9
    } vsar_mode_t;

    localparam logic [ADDR_W-1:0] NT_CLEAR_MASK = 15'h73FF;
    localparam logic [ADDR_W-1:0] CX_CLEAR_MASK = 15'h7FE0;
    localparam logic [ADDR_W-1:0] CY_CLEAR_MASK = 15'h7C1F;
    localparam logic [ADDR_W-1:0] SCROLL_Y_KEEP = 15'h0C1F;
    localparam logic [ADDR_W-1:0] HCOPY_KEEP    = 15'h7BE0;
    localparam logic [ADDR_W-1:0] HCOPY_TAKE    = 15'h041F;
    localparam logic [ADDR_W-1:0] NT_X_BIT      = 15'h0400;
    localparam logic [ADDR_W-1:0] NT_Y_BIT      = 15'h0800;
    localparam logic [ADDR_W-1:0] FINE_Y_STEP   = 15'h1000;
    localparam logic [ADDR_W-1:0] COARSE_Y_STEP = 15'h0020;
    localparam logic [4:0]        COARSE_Y_LAST = 5'd29;
    localparam logic [4:0]        COARSE_MAX    = 5'd31;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_counter;
        logic [ADDR_W-1:0] addr_latch;
        logic [FINE_W-1:0] fine_scroll;
        logic              toggle;
        logic              step_by_32;
        logic              bg_enable;
        logic              sprite_enable;
    } vsar_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] vram_addr;
        logic [FINE_W-1:0] fine_x;
        logic              write_toggle;
        logic              a12_rise;
    } vsar_result_t;

endpackage
`default_nettype wire

### hw/rtl/vsar_ifs.sv
// Handshake channel interfaces for events and results.
`default_nettype none
interface vsar_evt_if;
    import vsar_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] data;
    modport source (output valid, output mode, output data, input ready);
    modport sink (input valid, input mode, input data, output ready);
endinterface

interface vsar_res_if;
    import vsar_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] vram_addr;
    logic [FINE_W-1:0] fine_x;
    logic              write_toggle;
    logic              a12_rise;
    modport source (output valid, output vram_addr, output fine_x, output write_toggle,
                    output a12_rise, input ready);
    modport sink (input valid, input vram_addr, input fine_x, input write_toggle,
                  input a12_rise, output ready);
endinterface
`default_nettype wire

### hw/rtl/vsar_update.sv
// Next-state and result logic for one event.
`default_nettype none
module vsar_update (
    input  wire vsar_pkg::vsar_state_t        cur,
    input  wire logic [vsar_pkg::MODE_W-1:0]  mode,
    input  wire logic [vsar_pkg::DATA_W-1:0]  data,
    output vsar_pkg::vsar_state_t             nxt,
    output vsar_pkg::vsar_result_t            res
);
    import vsar_pkg::*;

    function automatic logic [ADDR_W-1:0] step_coarse_x(input logic [ADDR_W-1:0] v);
        if (v[4:0] == COARSE_MAX) begin
            return (v & CX_CLEAR_MASK) ^ NT_X_BIT;
        end
        return v + 15'd1;
    endfunction

    function automatic logic [ADDR_W-1:0] step_fine_y(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] w;
        if (v[14:12] != 3'd7) begin
            return v + FINE_Y_STEP;
        end
        w = {3'b000, v[11:0]};
        if (w[9:5] == COARSE_Y_LAST) begin
            return (w & CY_CLEAR_MASK) ^ NT_Y_BIT;
        end
        if (w[9:5] == COARSE_MAX) begin
            return w & CY_CLEAR_MASK;
        end
        return w + COARSE_Y_STEP;
    endfunction

    logic [ADDR_W-1:0] v;
    logic              rendering;

    assign rendering = cur.bg_enable | cur.sprite_enable;

    always_comb
    begin
        nxt = cur;
        v   = cur.addr_counter;
        case (vsar_mode_t'(mode))
            MODE_CTRL_WR:
            begin
                nxt.addr_latch = (cur.addr_latch & NT_CLEAR_MASK) | {3'b000, data[1:0], 10'd0};
                nxt.step_by_32 = data[2];
            end
            MODE_MASK_WR:
            begin
                nxt.bg_enable     = data[3];
                nxt.sprite_enable = data[4];
            end
            MODE_SCROLL_WR:
            begin
                if (cur.toggle)
                begin
                    nxt.addr_latch = (cur.addr_latch & SCROLL_Y_KEEP)
                                   | {data[2:0], 2'b00, data[7:3], 5'd0};
                end
                else
                begin
                    nxt.fine_scroll = data[2:0];
                    nxt.addr_latch  = (cur.addr_latch & CX_CLEAR_MASK) | {10'd0, data[7:3]};
                end
                nxt.toggle = ~cur.toggle;
            end
            MODE_ADDR_WR:
            begin
                if (cur.toggle)
                begin
                    nxt.addr_latch = {cur.addr_latch[14:8], data};
                    v              = {cur.addr_latch[14:8], data};
                end
                else
                begin
                    nxt.addr_latch = {1'b0, data[5:0], cur.addr_latch[7:0]};
                end
                nxt.toggle = ~cur.toggle;
            end
            MODE_DATA_WR, MODE_DATA_RD:
            begin
                v = cur.addr_counter + (cur.step_by_32 ? 15'd32 : 15'd1);
            end
            MODE_STATUS_RD:
            begin
                nxt.toggle = 1'b0;
            end
            MODE_TILE_TICK:
            begin
                if (cur.bg_enable)
                begin
                    v = step_coarse_x(cur.addr_counter);
                end
            end
            MODE_LINE_END:
            begin
                if (rendering)
                begin
                    v = (step_fine_y(cur.addr_counter) & HCOPY_KEEP)
                      | (cur.addr_latch & HCOPY_TAKE);
                end
            end
            MODE_PRERENDER_END:
            begin
                if (rendering)
                begin
                    v = cur.addr_latch;
                end
            end
            default:
            begin
            end
        endcase
        nxt.addr_counter = v;
    end

    assign res.vram_addr    = v;
    assign res.fine_x       = nxt.fine_scroll;
    assign res.write_toggle = nxt.toggle;
    assign res.a12_rise     = ~cur.addr_counter[12] & v[12];

endmodule
`default_nettype wire

### hw/rtl/video_scroll_address_registers_core.sv
// Top level of the video scroll and address registers with input and result stages.
//
//  channel | dir | fields                                   | beat
//  evt     | in  | mode[3:0], data[7:0]                     | valid & ready
//  res     | out | vram_addr[14:0], fine_x[2:0],            | valid & ready
//          |     | write_toggle, a12_rise                   |
//
// One event per clock unless res stalls; evt accepts each event into the event register.
// The event register feeds the update logic, which writes the state and the result register.
// Asynchronous active-low reset clears all scroll state and both valid flags.
// A stalled res holds its beat; evt takes at most one more event into the input register.
`default_nettype none
module video_scroll_address_registers_core (
    input wire logic clk,
    input wire logic rst_n,
    vsar_evt_if.sink   evt,
    vsar_res_if.source res
);
    import vsar_pkg::*;

    logic              evt_valid_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [DATA_W-1:0] data_reg;
    vsar_state_t       state_reg;
    vsar_state_t       state_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    vsar_result_t      res_reg;
    vsar_result_t      res_next;
    logic              advance;
    logic              evt_take;

    assign advance        = evt_valid_reg & (~res_valid_reg | res.ready);
    assign evt.ready      = ~evt_valid_reg | advance;
    assign evt_take       = evt.valid & evt.ready;
    assign res_valid_next = advance | (res_valid_reg & ~res.ready);

    vsar_update u_update (
        .cur  (state_reg),
        .mode (mode_reg),
        .data (data_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            evt_valid_reg <= evt_take | (evt_valid_reg & ~advance);
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            mode_reg <= evt.mode;
            data_reg <= evt.data;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.vram_addr    = res_reg.vram_addr;
    assign res.fine_x       = res_reg.fine_x;
    assign res.write_toggle = res_reg.write_toggle;
    assign res.a12_rise     = res_reg.a12_rise;

endmodule
`default_nettype wire

### hw/rtl/vsar_checker.sv
// Port-level assertions for the video scroll and address registers, with their bind.
`default_nettype none
module vsar_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        evt_valid,
    input wire logic        evt_ready,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [14:0] res_vram_addr,
    input wire logic [2:0]  res_fine_x,
    input wire logic        res_write_toggle,
    input wire logic        res_a12_rise
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_vram_addr)
            && $stable(res_fine_x) && $stable(res_write_toggle) && $stable(res_a12_rise))
        else $error("result beat changed while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !evt_ready |-> res_valid && !res_ready)
        else $error("event channel stalled without a stalled result");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |-> ##2 res_valid)
        else $error("accepted event produced no result beat in time");

    a_a12_bit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_a12_rise |-> res_vram_addr[12])
        else $error("bit 12 rise flagged with bit 12 clear");

endmodule

bind video_scroll_address_registers_core vsar_checker u_vsar_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .evt_valid        (evt.valid),
    .evt_ready        (evt.ready),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_vram_addr    (res.vram_addr),
    .res_fine_x       (res.fine_x),
    .res_write_toggle (res.write_toggle),
    .res_a12_rise     (res.a12_rise)
);
`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the video scroll and address registers core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vsar_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 4'd10;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 4'd15;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int QUIET_ITEMS   = 150;
    localparam int PRINT_LIMIT   = 50;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] data;
        bit                drain;
    } bus_event_t;

    logic clk;
    logic rst_n;

    vsar_evt_if evt_ch();
    vsar_res_if res_ch();

    video_scroll_address_registers_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch)
    );

    bus_event_t   event_q[$];
    vsar_result_t reg_view_q[$];
    bus_event_t   next_event;
    vsar_result_t want;
    bit           drain_flag = 0;
    bit           evt_taken = 0;
    int           send_gap = 0;
    int           hold_left = 0;
    int           burst_odds = 2;
    int           mismatch_count = 0;

    logic [ADDR_W-1:0] vaddr;
    logic [ADDR_W-1:0] taddr;
    logic [FINE_W-1:0] xfine;
    logic              wtoggle;
    logic              inc32;
    logic              show_bg;
    logic              show_spr;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch in %s at %0t: got %0h, expected %0h", what, $realtime, got,
                     exp_val);
        mismatch_count++;
    endtask

    task automatic queue_event(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] d);
        event_q.push_back('{m, d, drain_flag});
        drain_flag = 0;
    endtask

    function automatic vsar_result_t apply_event(input logic [MODE_W-1:0] m,
                                                 input logic [DATA_W-1:0] d);
        logic [ADDR_W-1:0] prior;
        logic [ADDR_W-1:0] v;
        logic [4:0]        row;
        logic              rendering;
        vsar_result_t      r;
        prior = vaddr;
        v = vaddr;
        rendering = show_bg | show_spr;
        case (m)
            MODE_CTRL_WR:
            begin
                taddr = (taddr & NT_CLEAR_MASK) | {3'b000, d[1:0], 10'b0};
                inc32 = d[2];
            end
            MODE_MASK_WR:
            begin
                show_bg = d[3];
                show_spr = d[4];
            end
            MODE_SCROLL_WR:
            begin
                if (wtoggle)
                    taddr = (taddr & SCROLL_Y_KEEP) | {d[2:0], 2'b00, d[7:3], 5'b0};
                else
                begin
                    xfine = d[2:0];
                    taddr = (taddr & CX_CLEAR_MASK) | {10'b0, d[7:3]};
                end
                wtoggle = ~wtoggle;
            end
            MODE_ADDR_WR:
            begin
                if (wtoggle)
                begin
                    taddr = {taddr[14:8], d};
                    v = taddr;
                end
                else
                    taddr = {1'b0, d[5:0], taddr[7:0]};
                wtoggle = ~wtoggle;
            end
            MODE_DATA_WR, MODE_DATA_RD:
                v = v + (inc32 ? 15'd32 : 15'd1);
            MODE_STATUS_RD:
                wtoggle = 1'b0;
            MODE_TILE_TICK:
            begin
                if (show_bg)
                begin
                    if (v[4:0] == COARSE_MAX)
                        v = {v[14:5], 5'b0} ^ NT_X_BIT;
                    else
                        v = v + 15'd1;
                end
            end
            MODE_LINE_END:
            begin
                if (rendering)
                begin
                    if (v[14:12] != 3'd7)
                        v = v + FINE_Y_STEP;
                    else
                    begin
                        v[14:12] = 3'd0;
                        row = v[9:5];
                        if (row == COARSE_Y_LAST)
                            v = (v & CY_CLEAR_MASK) ^ NT_Y_BIT;
                        else if (row == COARSE_MAX)
                            v = v & CY_CLEAR_MASK;
                        else
                            v = v + COARSE_Y_STEP;
                    end
                    v = (v & HCOPY_KEEP) | (taddr & HCOPY_TAKE);
                end
            end
            MODE_PRERENDER_END:
            begin
                if (rendering)
                    v = taddr;
            end
            default:
            begin
            end
        endcase
        vaddr = v;
        r.vram_addr = vaddr;
        r.fine_x = xfine;
        r.write_toggle = wtoggle;
        r.a12_rise = ~prior[12] & vaddr[12];
        return r;
    endfunction

    always @(posedge clk)
    begin
        evt_taken <= rst_n && evt_ch.valid && evt_ch.ready;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (reg_view_q.size() == 0)
                report_mismatch("unexpected beat", int'(res_ch.vram_addr), 0);
            else
            begin
                want = reg_view_q.pop_front();
                if (res_ch.vram_addr !== want.vram_addr)
                    report_mismatch("vram_addr", int'(res_ch.vram_addr),
                                    int'(want.vram_addr));
                if (res_ch.fine_x !== want.fine_x)
                    report_mismatch("fine_x", int'(res_ch.fine_x), int'(want.fine_x));
                if (res_ch.write_toggle !== want.write_toggle)
                    report_mismatch("write_toggle", int'(res_ch.write_toggle),
                                    int'(want.write_toggle));
                if (res_ch.a12_rise !== want.a12_rise)
                    report_mismatch("a12_rise", int'(res_ch.a12_rise), int'(want.a12_rise));
            end
        end
        if (rst_n && evt_ch.valid && evt_ch.ready)
            reg_view_q.push_back(apply_event(evt_ch.mode, evt_ch.data));
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 199) == 0)
                burst_odds <= $urandom_range(0, 3);
            if (!evt_ch.valid || evt_taken)
            begin
                if (send_gap > 0)
                begin
                    evt_ch.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (event_q.size() == 0 || (event_q[0].drain && reg_view_q.size() != 0))
                    evt_ch.valid <= 1'b0;
                else if (event_q.size() > QUIET_ITEMS && burst_odds != 0 &&
                         $urandom_range(1, 12) <= burst_odds)
                begin
                    evt_ch.valid <= 1'b0;
                    send_gap <= $urandom_range(0, 13);
                end
                else
                begin
                    next_event = event_q.pop_front();
                    evt_ch.valid <= 1'b1;
                    evt_ch.mode <= next_event.mode;
                    evt_ch.data <= next_event.data;
                end
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (event_q.size() > QUIET_ITEMS && burst_odds != 0 &&
                     $urandom_range(1, 12) <= burst_odds)
            begin
                res_ch.ready <= 1'b0;
                hold_left <= $urandom_range(0, 13);
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int target;
        int kind;
        int n;
        logic [DATA_W-1:0] d;
        rst_n = 1'b0;
        evt_ch.valid = 1'b0;
        evt_ch.mode = MODE_CTRL_WR;
        evt_ch.data = '0;
        res_ch.ready = 1'b0;
        vaddr = '0;
        taddr = '0;
        xfine = '0;
        wtoggle = 1'b0;
        inc32 = 1'b0;
        show_bg = 1'b0;
        show_spr = 1'b0;

        queue_event(MODE_STATUS_RD, 8'h00);
        queue_event(MODE_UNUSED_LAST, 8'hFF);
        queue_event(MODE_UNUSED_FIRST, 8'h00);
        queue_event(MODE_CTRL_WR, 8'hFF);
        queue_event(MODE_MASK_WR, 8'h18);
        queue_event(MODE_SCROLL_WR, 8'hFF);
        queue_event(MODE_SCROLL_WR, 8'hFF);
        queue_event(MODE_PRERENDER_END, 8'h00);
        queue_event(MODE_DATA_WR, 8'h00);
        queue_event(MODE_CTRL_WR, 8'h00);
        queue_event(MODE_TILE_TICK, 8'hFF);
        queue_event(MODE_LINE_END, 8'h00);
        queue_event(MODE_DATA_RD, 8'hFF);
        queue_event(MODE_ADDR_WR, 8'hFF);
        queue_event(MODE_ADDR_WR, 8'hFF);
        queue_event(MODE_ADDR_WR, 8'h00);
        queue_event(MODE_STATUS_RD, 8'hFF);
        queue_event(MODE_ADDR_WR, 8'h00);
        queue_event(MODE_ADDR_WR, 8'h00);
        queue_event(MODE_SCROLL_WR, 8'h00);
        queue_event(MODE_SCROLL_WR, 8'hEF);
        queue_event(MODE_PRERENDER_END, 8'h00);
        queue_event(MODE_LINE_END, 8'h00);
        queue_event(MODE_MASK_WR, 8'h10);
        queue_event(MODE_TILE_TICK, 8'h00);
        queue_event(MODE_LINE_END, 8'h00);
        queue_event(MODE_MASK_WR, 8'h00);
        queue_event(MODE_LINE_END, 8'h00);
        queue_event(MODE_TILE_TICK, 8'h00);

        target = event_q.size() + RANDOM_ITEMS;
        drain_flag = 1;
        while (event_q.size() < target)
        begin
            if ($urandom_range(0, 299) == 0)
                drain_flag = 1;
            kind = $urandom_range(0, 9);
            case (kind)
                0:
                begin
                    n = $urandom_range(1, 4);
                    repeat (n)
                        queue_event(MODE_W'($urandom_range(MODE_CTRL_WR, MODE_UNUSED_LAST)),
                                    DATA_W'($urandom_range(0, 255)));
                end
                1:
                begin
                    if ($urandom_range(0, 1))
                        queue_event(MODE_STATUS_RD, DATA_W'($urandom_range(0, 255)));
                    queue_event(MODE_SCROLL_WR, DATA_W'($urandom_range(0, 255)));
                    queue_event(MODE_SCROLL_WR, DATA_W'($urandom_range(0, 255)));
                end
                2:
                begin
                    queue_event(MODE_STATUS_RD, DATA_W'($urandom_range(0, 255)));
                    queue_event(MODE_ADDR_WR, DATA_W'($urandom_range(0, 255)));
                    queue_event(MODE_ADDR_WR, DATA_W'($urandom_range(0, 255)));
                    n = $urandom_range(0, 6);
                    repeat (n)
                        queue_event($urandom_range(0, 1) ? MODE_DATA_WR : MODE_DATA_RD,
                                    DATA_W'($urandom_range(0, 255)));
                end
                3:
                    queue_event(MODE_CTRL_WR, DATA_W'($urandom_range(0, 255)));
                4:
                begin
                    d = DATA_W'($urandom_range(0, 255));
                    if ($urandom_range(0, 3) != 0)
                        d[3] = 1'b1;
                    queue_event(MODE_MASK_WR, d);
                end
                5, 6, 7:
                begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 34)
                                                    : $urandom_range(0, 8);
                    repeat (n)
                        queue_event(MODE_TILE_TICK, DATA_W'($urandom_range(0, 255)));
                    queue_event(MODE_LINE_END, DATA_W'($urandom_range(0, 255)));
                end
                8:
                begin
                    queue_event(MODE_STATUS_RD, DATA_W'($urandom_range(0, 255)));
                    queue_event(MODE_SCROLL_WR, DATA_W'($urandom_range(0, 255)));
                    queue_event(MODE_SCROLL_WR, DATA_W'($urandom_range(0, 255)));
                    queue_event(MODE_PRERENDER_END, DATA_W'($urandom_range(0, 255)));
                    n = $urandom_range(1, 10);
                    repeat (n)
                    begin
                        queue_event(MODE_TILE_TICK, DATA_W'($urandom_range(0, 255)));
                        queue_event(MODE_LINE_END, DATA_W'($urandom_range(0, 255)));
                    end
                end
                default:
                begin
                    queue_event($urandom_range(0, 1) ? MODE_SCROLL_WR : MODE_ADDR_WR,
                                DATA_W'($urandom_range(0, 255)));
                    queue_event(MODE_W'($urandom_range(MODE_DATA_WR, MODE_DATA_RD)),
                                DATA_W'($urandom_range(0, 255)));
                end
            endcase
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (event_q.size() == 0 && !evt_ch.valid);
        wait (reg_view_q.size() == 0);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && reg_view_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
